/* hdl/soa_pkg.sv */
// Shared constants, request codes and control types for the slot owner allocator.
`timescale 1ns / 1ps

package soa_pkg;

  localparam int REQ_W           = 2;
  localparam int SLOT_W          = 7;
  localparam int CAP_W           = 7;
  localparam int OWNER_ID_W      = 16;
  localparam int OWNER_W_MAX     = 32;
  localparam int SLOTS_DEF       = 64;
  localparam int OWNER_WIDTH_DEF = 16;
  localparam int CAP_MAX         = (2 ** CAP_W) - 1;

  localparam int GRP_SIZE = 8;
  localparam int GRP_W    = 3;

  localparam int IN_FIELDS_W  = SLOT_W + OWNER_ID_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = SLOT_W + OWNER_ID_W + 2 * CAP_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [REQ_W-1:0] REQ_ALLOC   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CLAIM   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd2;
  localparam logic [REQ_W-1:0] REQ_QUERY   = 2'd3;

  typedef struct packed {
    logic load;
    logic search;
    logic commit;
    logic cfg_wr;
  } soa_cmd_t;

  typedef struct packed {
    logic out_free;
  } soa_sts_t;

endpackage

/* hdl/soa_ctrl.sv */
// Request sequencer: accept, table read and free search, update and result load.
`timescale 1ns / 1ps

module soa_ctrl import soa_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  soa_sts_t sts,
  output soa_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign s_tready   = (state == ST_IDLE);
  assign cfg_ready  = (state == ST_IDLE);
  assign cmd.load   = s_tvalid && s_tready;
  assign cmd.search = (state == ST_SEARCH);
  assign cmd.commit = (state == ST_COMMIT) && sts.out_free;
  assign cmd.cfg_wr = cfg_valid && cfg_ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.load) state_next = ST_SEARCH;
      end
      ST_SEARCH: begin
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* hdl/soa_datapath.sv */
// Owner table, occupancy bitmap, two-level free search, counters and result register.
`timescale 1ns / 1ps

module soa_datapath import soa_pkg::*; #(
  parameter int SLOTS       = SLOTS_DEF,
  parameter int OWNER_WIDTH = OWNER_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  soa_cmd_t               cmd,
  output soa_sts_t               sts,
  input  logic [CAP_W-1:0]       cfg_data,
  input  logic [REQ_W-1:0]       in_req,
  input  logic [SLOT_W-1:0]      in_slot,
  input  logic [OWNER_ID_W-1:0]  in_owner,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tuser
);

  localparam int EFF_SLOTS = (SLOTS < CAP_MAX) ? SLOTS : CAP_MAX;
  localparam int IDX_W     = $clog2(EFF_SLOTS);
  localparam int NGRP      = (EFF_SLOTS + GRP_SIZE - 1) / GRP_SIZE;
  localparam int OCC_W     = NGRP * GRP_SIZE;
  localparam int OCC_IW    = $clog2(OCC_W);

  logic [CAP_W-1:0]       capacity;
  logic [CAP_W-1:0]       used_total;
  logic [OCC_W-1:0]       occ;
  logic [OWNER_WIDTH-1:0] mem [EFF_SLOTS];
  logic [OWNER_WIDTH-1:0] rd_data;

  logic [REQ_W-1:0]       req_r;
  logic [SLOT_W-1:0]      slot_r;
  logic [OWNER_WIDTH-1:0] owner_r;

  logic [NGRP-1:0]        grp_any;
  logic [GRP_W-1:0]       grp_pos [NGRP];
  logic [NGRP-1:0]        grp_any_c;
  logic [GRP_W-1:0]       grp_pos_c [NGRP];
  logic [OCC_W-1:0]       free_vec;

  logic [CAP_W-1:0]       cap_eff;
  logic [CAP_W-1:0]       sidx;
  logic                   slot_ok;
  logic                   occ_s;
  logic                   found;
  logic [CAP_W-1:0]       ffree;

  logic                   ok;
  logic                   do_set;
  logic                   do_clr;
  logic [CAP_W-1:0]       tgt;
  logic [SLOT_W-1:0]      slot_res;
  logic [OWNER_WIDTH-1:0] owner_res;
  logic [CAP_W-1:0]       used_next;
  logic [CAP_W-1:0]       free_cnt;
  logic [OWNER_ID_W-1:0]  owner_out;

  assign cap_eff = (capacity > CAP_W'(EFF_SLOTS)) ? CAP_W'(EFF_SLOTS) : capacity;
  assign sidx    = slot_r - SLOT_W'(1);
  assign slot_ok = (cap_eff != '0) && (slot_r != '0) && (slot_r <= cap_eff);
  assign occ_s   = slot_ok && occ[sidx[OCC_IW-1:0]];

  // first level: lowest free bit inside each group of eight
  always_comb begin
    for (int i = 0; i < OCC_W; i++) begin
      free_vec[i] = !occ[i] && (CAP_W'(i) < cap_eff);
    end
    for (int g = 0; g < NGRP; g++) begin
      grp_any_c[g] = |free_vec[g*GRP_SIZE +: GRP_SIZE];
      grp_pos_c[g] = '0;
      for (int b = GRP_SIZE - 1; b >= 0; b--) begin
        if (free_vec[g*GRP_SIZE + b]) grp_pos_c[g] = GRP_W'(b);
      end
    end
  end

  // second level: lowest group holding a free slot
  always_comb begin
    found = 1'b0;
    ffree = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        found = 1'b1;
        ffree = CAP_W'(g * GRP_SIZE) + CAP_W'(grp_pos[g]);
      end
    end
  end

  always_comb begin
    ok        = 1'b0;
    do_set    = 1'b0;
    do_clr    = 1'b0;
    tgt       = sidx;
    slot_res  = '0;
    owner_res = '0;
    case (req_r)
      REQ_ALLOC: begin
        if ((cap_eff != '0) && (owner_r != '0) && found) begin
          ok       = 1'b1;
          do_set   = 1'b1;
          tgt      = ffree;
          slot_res = ffree + CAP_W'(1);
        end
      end
      REQ_CLAIM: begin
        if (slot_ok && (owner_r != '0) && !occ_s) begin
          ok       = 1'b1;
          do_set   = 1'b1;
          slot_res = slot_r;
        end
      end
      REQ_RELEASE: begin
        if (occ_s) begin
          ok        = 1'b1;
          do_clr    = 1'b1;
          owner_res = rd_data;
        end
      end
      REQ_QUERY: begin
        if (slot_ok) begin
          ok        = 1'b1;
          owner_res = occ_s ? rd_data : '0;
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  assign used_next = used_total + CAP_W'(do_set) - CAP_W'(do_clr);
  assign free_cnt  = cap_eff - used_next;
  assign owner_out = OWNER_ID_W'(OWNER_W_MAX'(owner_res));
  assign sts.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity   <= '0;
      used_total <= '0;
      occ        <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cmd.cfg_wr) begin
        capacity   <= cfg_data;
        used_total <= '0;
        occ        <= '0;
      end
      if (cmd.commit) begin
        if (do_set) occ[tgt[OCC_IW-1:0]] <= 1'b1;
        if (do_clr) occ[tgt[OCC_IW-1:0]] <= 1'b0;
        used_total <= used_next;
        m_tvalid   <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r   <= in_req;
      slot_r  <= in_slot;
      owner_r <= OWNER_WIDTH'(OWNER_W_MAX'(in_owner));
    end
    if (cmd.search) begin
      grp_any <= grp_any_c;
      for (int g = 0; g < NGRP; g++) begin
        grp_pos[g] <= grp_pos_c[g];
      end
    end
    if (cmd.commit) begin
      m_tdata <= OUT_TDATA_W'({free_cnt, used_next, owner_out, slot_res});
      m_tuser <= !ok;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.search) rd_data <= mem[sidx[IDX_W-1:0]];
    if (cmd.commit && do_set) mem[tgt[IDX_W-1:0]] <= owner_r;
  end

  a_used_matches_bitmap: assert property (@(posedge clk) disable iff (rst)
    used_total == CAP_W'($countones(occ)))
    else $error("used count differs from occupancy bitmap");

  a_used_within_cap: assert property (@(posedge clk) disable iff (rst)
    used_total <= cap_eff)
    else $error("used count exceeds capacity");

  a_commit_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!m_tvalid || m_tready))
    else $error("result overwritten before it was taken");

  a_commit_gives_result: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> m_tvalid)
    else $error("result register not loaded after update");

endmodule

/* hdl/slot_owner_allocator_top.sv */
// Top level of the slot owner allocator: sequencer plus table datapath.
//
//   port group  dir  contents
//   cfg_*       in   capacity register write (cfg_data, 7 bits)
//   s_*         in   request item: tuser req_type, tdata slot_number/owner_id
//   m_*         out  result item: tuser status, tdata slot/owner/used/free
//
// Each item is accepted, then gets an owner table read with a grouped free-slot
// search, then a table and bitmap update with the result loaded into m_*.
// The owner table is one memory read port feeding the update cycle.
// Reset or a capacity write clears the occupancy bitmap at once; no sweep.
// A waiting result holds the update cycle until m_tready; a new request is
// accepted while the previous result still waits.
`timescale 1ns / 1ps

module slot_owner_allocator_top import soa_pkg::*; #(
  parameter int SLOTS       = SLOTS_DEF,
  parameter int OWNER_WIDTH = OWNER_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CAP_W-1:0]       cfg_data,   // capacity
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,    // slot_number, owner_id
  input  logic [REQ_W-1:0]       s_tuser,    // req_type
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,    // slot_result, owner_result, used_count, free_count
  output logic                   m_tuser     // status
);

  soa_cmd_t cmd;
  soa_sts_t sts;

  soa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  soa_datapath #(
    .SLOTS       (SLOTS),
    .OWNER_WIDTH (OWNER_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .cfg_data (cfg_data),
    .in_req   (s_tuser),
    .in_slot  (s_tdata[SLOT_W-1:0]),
    .in_owner (s_tdata[SLOT_W +: OWNER_ID_W]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

/* dv/tb_slot_owner_allocator_top.sv */
// Self-checking testbench for the slot owner allocator: directed table, then random phases.
`timescale 1ns / 1ps

module tb_slot_owner_allocator_top;
  import soa_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 4;
  localparam int DIR_ROWS = 28;
  localparam int PHASES = 8;

  typedef struct packed {
    logic                  status;
    logic [SLOT_W-1:0]     slot;
    logic [OWNER_ID_W-1:0] owner;
    logic [CAP_W-1:0]      used;
    logic [CAP_W-1:0]      free;
  } alloc_result_t;

  typedef struct {
    bit                    is_cfg;
    logic [CAP_W-1:0]      cfg_val;
    logic [REQ_W-1:0]      req;
    logic [SLOT_W-1:0]     slot;
    logic [OWNER_ID_W-1:0] owner;
    bit                    typed;
    alloc_result_t         res;
  } dir_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CAP_W-1:0]       cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;   // slot_number, owner_id
  logic [REQ_W-1:0]       s_tuser = '0;   // req_type
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;        // slot_result, owner_result, used_count, free_count
  logic                   m_tuser;        // status

  // predicted table state
  logic [OWNER_ID_W-1:0] owner_table [SLOTS_DEF];
  logic [CAP_W-1:0]      capacity_reg;
  logic [CAP_W-1:0]      used_slots;

  alloc_result_t pending_results [$];
  int mismatch_count = 0;
  int idle_pct = 30;
  int cycle_count = 0;
  dir_row_t directed_rows [DIR_ROWS];

  slot_owner_allocator_top DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  function automatic void clear_table();
    for (int i = 0; i < SLOTS_DEF; i++) owner_table[i] = '0;
    used_slots = '0;
  endfunction

  function automatic alloc_result_t apply_request(logic [REQ_W-1:0] req,
                                                  logic [SLOT_W-1:0] slot,
                                                  logic [OWNER_ID_W-1:0] owner);
    int cap;
    bit slot_ok;
    alloc_result_t r;
    cap = (capacity_reg > SLOTS_DEF) ? SLOTS_DEF : int'(capacity_reg);
    r = '0;
    r.status = 1'b1;
    slot_ok = (cap != 0) && (slot >= 1) && (slot <= cap);
    case (req)
      REQ_ALLOC: begin
        if (cap != 0 && owner != 0) begin
          for (int i = 0; i < cap; i++) begin
            if (owner_table[i] == 0) begin
              owner_table[i] = owner;
              used_slots++;
              r.slot = SLOT_W'(i + 1);
              r.status = 1'b0;
              break;
            end
          end
        end
      end
      REQ_CLAIM: begin
        if (slot_ok && owner != 0 && owner_table[slot-1] == 0) begin
          owner_table[slot-1] = owner;
          used_slots++;
          r.slot = slot;
          r.status = 1'b0;
        end
      end
      REQ_RELEASE: begin
        if (slot_ok && owner_table[slot-1] != 0) begin
          r.owner = owner_table[slot-1];
          owner_table[slot-1] = '0;
          if (used_slots != 0) used_slots--;
          r.status = 1'b0;
        end
      end
      REQ_QUERY: begin
        if (slot_ok) begin
          r.owner = owner_table[slot-1];
          r.status = 1'b0;
        end
      end
    endcase
    r.used = used_slots;
    r.free = (cap >= used_slots) ? CAP_W'(cap - used_slots) : '0;
    return r;
  endfunction

  function automatic logic [SLOT_W-1:0] pick_slot(int eff, bit want_busy);
    logic [SLOT_W-1:0] s;
    if (eff == 0) return SLOT_W'($urandom_range(127));
    s = SLOT_W'($urandom_range(eff, 1));
    for (int t = 0; t < 8; t++) begin
      if ((owner_table[s-1] != 0) == want_busy) break;
      s = SLOT_W'($urandom_range(eff, 1));
    end
    return s;
  endfunction

  function automatic logic [OWNER_ID_W-1:0] rand_owner();
    case ($urandom_range(9))
      0: return 16'hFFFF;
      1: return 16'h0001;
      default: return OWNER_ID_W'($urandom_range(65535, 1));
    endcase
  endfunction

  task automatic note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: %s", $time, msg);
  endtask

  task automatic hold_requests();
    s_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_request(logic [REQ_W-1:0] req, logic [SLOT_W-1:0] slot,
                              logic [OWNER_ID_W-1:0] owner, bit use_typed,
                              alloc_result_t typed_res);
    alloc_result_t pred;
    bit accepted;
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= IN_TDATA_W'({owner, slot});
    do begin
      @(negedge clk);
      accepted = s_tready;
      @(posedge clk);
    end while (!accepted);
    pred = apply_request(req, slot, owner);
    pending_results.push_back(use_typed ? typed_res : pred);
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] value);
    bit accepted;
    hold_requests();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do begin
      @(negedge clk);
      accepted = cfg_ready;
      @(posedge clk);
    end while (!accepted);
    cfg_valid <= 1'b0;
    capacity_reg = value;
    clear_table();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // handshake inputs only change at posedge, so the negedge sample decides acceptance
  always @(negedge clk) begin : result_monitor
    alloc_result_t got;
    alloc_result_t want;
    bit bad;
    if (!rst && m_tvalid && m_tready) begin
      got.status = m_tuser;
      got.slot   = m_tdata[6:0];
      got.owner  = m_tdata[22:7];
      got.used   = m_tdata[29:23];
      got.free   = m_tdata[36:30];
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("result with none expected: st=%0d slot=%0d own=%h used=%0d free=%0d",
                      got.status, got.slot, got.owner, got.used, got.free));
      end else begin
        want = pending_results.pop_front();
        bad = (got.status !== want.status) || (got.slot !== want.slot) ||
              (got.owner !== want.owner) || (got.used !== want.used) ||
              (got.free !== want.free);
        if (bad) begin
          note_mismatch($sformatf("exp st=%0d slot=%0d own=%h used=%0d free=%0d, got st=%0d slot=%0d own=%h used=%0d free=%0d",
                        want.status, want.slot, want.owner, want.used, want.free,
                        got.status, got.slot, got.owner, got.used, got.free));
        end
      end
    end
  end

  initial begin : stimulus
    logic [CAP_W-1:0] phase_caps [PHASES];
    logic [REQ_W-1:0] req;
    logic [SLOT_W-1:0] slot;
    logic [OWNER_ID_W-1:0] owner;
    int eff;
    int n;
    int w;
    int alloc_w;

    capacity_reg = '0;
    clear_table();
    directed_rows = '{
      '{1'b0, 7'd0,   REQ_ALLOC,   7'd0,   16'h0005, 1'b1, '{1'b1, 7'd0, 16'd0, 7'd0, 7'd0}},
      '{1'b0, 7'd0,   REQ_QUERY,   7'd1,   16'h0000, 1'b1, '{1'b1, 7'd0, 16'd0, 7'd0, 7'd0}},
      '{1'b1, 7'd3,   REQ_ALLOC,   7'd0,   16'h0000, 1'b0, '0},
      '{1'b0, 7'd0,   REQ_ALLOC,   7'd0,   16'h0000, 1'b1, '{1'b1, 7'd0, 16'd0, 7'd0, 7'd3}},
      '{1'b0, 7'd0,   REQ_ALLOC,   7'd0,   16'hFFFF, 1'b1, '{1'b0, 7'd1, 16'd0, 7'd1, 7'd2}},
      '{1'b0, 7'd0,   REQ_ALLOC,   7'd127, 16'h0001, 1'b0, '0},
      '{1'b0, 7'd0,   REQ_CLAIM,   7'd3,   16'h1234, 1'b0, '0},
      '{1'b0, 7'd0,   REQ_ALLOC,   7'd0,   16'h0007, 1'b1, '{1'b1, 7'd0, 16'd0, 7'd3, 7'd0}},
      '{1'b0, 7'd0,   REQ_CLAIM,   7'd2,   16'h0009, 1'b0, '0},
      '{1'b0, 7'd0,   REQ_CLAIM,   7'd0,   16'h0009, 1'b1, '{1'b1, 7'd0, 16'd0, 7'd3, 7'd0}},
      '{1'b0, 7'd0,   REQ_CLAIM,   7'd4,   16'h0009, 1'b1, '{1'b1, 7'd0, 16'd0, 7'd3, 7'd0}},
      '{1'b0, 7'd0,   REQ_RELEASE, 7'd1,   16'h7FFF, 1'b0, '0},
      '{1'b0, 7'd0,   REQ_RELEASE, 7'd1,   16'h7FFF, 1'b0, '0},
      '{1'b0, 7'd0,   REQ_QUERY,   7'd3,   16'hFFFF, 1'b0, '0},
      '{1'b0, 7'd0,   REQ_QUERY,   7'd127, 16'h0000, 1'b1, '{1'b1, 7'd0, 16'd0, 7'd2, 7'd1}},
      '{1'b0, 7'd0,   REQ_CLAIM,   7'd1,   16'h0000, 1'b1, '{1'b1, 7'd0, 16'd0, 7'd2, 7'd1}},
      '{1'b0, 7'd0,   REQ_ALLOC,   7'd0,   16'h8000, 1'b0, '0},
      '{1'b1, 7'd127, REQ_ALLOC,   7'd0,   16'h0000, 1'b0, '0},
      '{1'b0, 7'd0,   REQ_CLAIM,   7'd64,  16'h5555, 1'b0, '0},
      '{1'b0, 7'd0,   REQ_RELEASE, 7'd65,  16'h0000, 1'b0, '0},
      '{1'b0, 7'd0,   REQ_QUERY,   7'd64,  16'h0000, 1'b0, '0},
      '{1'b0, 7'd0,   REQ_ALLOC,   7'd0,   16'hAAAA, 1'b0, '0},
      '{1'b1, 7'd0,   REQ_ALLOC,   7'd0,   16'h0000, 1'b0, '0},
      '{1'b0, 7'd0,   REQ_RELEASE, 7'd1,   16'h0000, 1'b1, '{1'b1, 7'd0, 16'd0, 7'd0, 7'd0}},
      '{1'b1, 7'd1,   REQ_ALLOC,   7'd0,   16'h0000, 1'b0, '0},
      '{1'b0, 7'd0,   REQ_ALLOC,   7'd0,   16'h0003, 1'b0, '0},
      '{1'b0, 7'd0,   REQ_ALLOC,   7'd0,   16'h0004, 1'b0, '0},
      '{1'b0, 7'd0,   REQ_RELEASE, 7'd1,   16'h0000, 1'b0, '0}
    };
    phase_caps = '{7'd64, 7'd1, 7'd127, 7'd2, 7'd0, 7'd5, 7'd64, 7'd33};

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        write_capacity(directed_rows[i].cfg_val);
      end else begin
        send_request(directed_rows[i].req, directed_rows[i].slot, directed_rows[i].owner,
                     directed_rows[i].typed, directed_rows[i].res);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      write_capacity(phase_caps[p]);
      idle_pct = (p == 3) ? 0 : 30;
      eff = (phase_caps[p] > SLOTS_DEF) ? SLOTS_DEF : int'(phase_caps[p]);
      n = (eff == 0) ? 40 : 120;
      alloc_w = (eff == SLOTS_DEF) ? 55 : 35;
      for (int k = 0; k < n; k++) begin
        if (p == 2 && k == 60) begin
          // let the pipeline run dry mid-phase
          hold_requests();
          wait_drained();
          @(posedge clk);
        end
        w = $urandom_range(99);
        if ($urandom_range(99) < 12) begin
          req   = REQ_W'($urandom_range(3));
          slot  = SLOT_W'($urandom_range(127));
          owner = ($urandom_range(3) == 0) ? '0 : OWNER_ID_W'($urandom_range(65535));
        end else if (w < alloc_w) begin
          req   = REQ_ALLOC;
          slot  = SLOT_W'($urandom_range(127));
          owner = rand_owner();
        end else if (w < alloc_w + 20) begin
          req   = REQ_CLAIM;
          slot  = pick_slot(eff, 1'b0);
          owner = rand_owner();
        end else if (w < alloc_w + 45) begin
          req   = REQ_RELEASE;
          slot  = pick_slot(eff, 1'b1);
          owner = OWNER_ID_W'($urandom_range(65535));
        end else begin
          req   = REQ_QUERY;
          slot  = pick_slot(eff, 1'($urandom_range(1)));
          owner = OWNER_ID_W'($urandom_range(65535));
        end
        send_request(req, slot, owner, 1'b0, '0);
      end
    end

    idle_pct = 30;
    hold_requests();
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
